>>> design/ymdf_pkg.sv
// ============================================================================
// ymdf_pkg
// Shared types and codes for the YMODEM packet deframer.
// ============================================================================
`default_nettype none

package ymdf_pkg;

    // CRC-16 accumulator type.
    typedef logic [15:0] crc_t;

    // Result kind codes.
    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_GOOD    = 3'd1;
    localparam logic [2:0] KIND_EOT     = 3'd2;
    localparam logic [2:0] KIND_ABORT   = 3'd3;
    localparam logic [2:0] KIND_BAD     = 3'd4;
    localparam logic [2:0] KIND_TIMEOUT = 3'd5;

    // Framing bytes seen while idle.
    localparam logic [7:0] BYTE_SOH   = 8'h01;
    localparam logic [7:0] BYTE_STX   = 8'h02;
    localparam logic [7:0] BYTE_EOT   = 8'h04;
    localparam logic [7:0] BYTE_CAN   = 8'h18;
    localparam logic [7:0] BYTE_UC_C  = 8'h43;
    localparam logic [7:0] BYTE_UC_A  = 8'h41;
    localparam logic [7:0] BYTE_LC_A  = 8'h61;

    // Payload lengths.
    localparam logic [10:0] LEN_SHORT = 11'd128;
    localparam logic [10:0] LEN_LONG  = 11'd1024;

endpackage

`default_nettype wire

>>> design/ymdf_crc_step.sv
// ============================================================================
// ymdf_crc_step
// One byte-wide step of CRC-16/XMODEM (polynomial 0x1021).
// ============================================================================
`default_nettype none

module ymdf_crc_step
    import ymdf_pkg::*;
(
    input  wire crc_t       crc_in,
    input  wire logic [7:0] data_in,
    output crc_t            crc_out
);

    logic [7:0] t0;
    logic [7:0] t1;

    // Fold the incoming byte with the top byte, then apply the nibble trick.
    assign t0 = crc_in[15:8] ^ data_in;
    assign t1 = t0 ^ {4'b0000, t0[7:4]};

    assign crc_out = {crc_in[7:0], 8'h00}
                   ^ {t1[3:0], 12'h000}
                   ^ {3'b000, t1, 5'b00000}
                   ^ {8'h00, t1};

endmodule

`default_nettype wire

>>> design/ymodem_packet_deframer_core.sv
// ============================================================================
// ymodem_packet_deframer_core
// Receives serial bytes or timeout events, frames YMODEM packets, checks the
// block number complement and CRC-16/XMODEM, streams payload and status.
// ============================================================================
// Path: an input transaction is held in the input register, and its result
// is then presented from the result register.
// Throughput: one input transaction per cycle unless a held result stalls it;
// the phase and CRC update between the two registers is combinational.
// Reset: rst_n clears the phase, counters and valid flags asynchronously.
`default_nettype none

module ymodem_packet_deframer_core
    import ymdf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] timed_out
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] data_byte, [17:8] byte_index,
                                        // [28:18] packet_length,
                                        // [36:29] block_number, [39:37] zero
    output logic [2:0]       m_tuser    // [2:0] kind
);

    // Phase codes.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CAN   = 3'd1;
    localparam logic [2:0] PH_BLK   = 3'd2;
    localparam logic [2:0] PH_CMP   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CRCHI = 3'd5;
    localparam logic [2:0] PH_CRCLO = 3'd6;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_tmo_reg;

    // Deframer state.
    logic [2:0] phase_reg, phase_next;
    logic       long_reg, long_next;
    logic [9:0] count_reg, count_next;
    logic [7:0] blk_reg, blk_next;
    logic       cmp_ok_reg, cmp_ok_next;
    crc_t       crc_reg, crc_next;

    // Result register.
    logic        out_valid_reg;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  data_reg, data_next;
    logic [9:0]  idx_reg, idx_next;
    logic [10:0] len_reg, len_next;
    logic [7:0]  oblk_reg, oblk_next;
    logic        emit;

    logic consume;
    crc_t crc_stepped;
    logic last_byte;

    // An item leaves the input register once the result slot is free.
    assign consume  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    ymdf_crc_step u_crc (
        .crc_in  (crc_reg),
        .data_in (in_byte_reg),
        .crc_out (crc_stepped)
    );

    assign last_byte = long_reg ? (count_reg == 10'd1023) : (count_reg == 10'd127);

    // Phase update and result selection for the held item.
    always_comb
    begin
        phase_next  = phase_reg;
        long_next   = long_reg;
        count_next  = count_reg;
        blk_next    = blk_reg;
        cmp_ok_next = cmp_ok_reg;
        crc_next    = crc_reg;
        emit        = 1'b0;
        kind_next   = KIND_BAD;
        data_next   = 8'h00;
        idx_next    = 10'd0;
        len_next    = 11'd0;
        oblk_next   = 8'h00;
        if (in_tmo_reg)
        begin
            phase_next = PH_IDLE;
            emit       = 1'b1;
            kind_next  = KIND_TIMEOUT;
        end
        else
        begin
            unique case (phase_reg)
                PH_CAN:
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    kind_next  = (in_byte_reg == BYTE_CAN) ? KIND_ABORT : KIND_BAD;
                end
                PH_BLK:
                begin
                    blk_next   = in_byte_reg;
                    phase_next = PH_CMP;
                end
                PH_CMP:
                begin
                    cmp_ok_next = ((in_byte_reg ^ 8'hFF) == blk_reg);
                    crc_next    = 16'h0000;
                    count_next  = 10'd0;
                    phase_next  = PH_DATA;
                end
                PH_DATA:
                begin
                    crc_next  = crc_stepped;
                    emit      = 1'b1;
                    kind_next = KIND_DATA;
                    data_next = in_byte_reg;
                    idx_next  = count_reg;
                    oblk_next = blk_reg;
                    if (last_byte)
                    begin
                        count_next = 10'd0;
                        phase_next = PH_CRCHI;
                    end
                    else
                    begin
                        count_next = count_reg + 10'd1;
                    end
                end
                PH_CRCHI:
                begin
                    crc_next   = crc_stepped;
                    phase_next = PH_CRCLO;
                end
                PH_CRCLO:
                begin
                    crc_next   = crc_stepped;
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    oblk_next  = blk_reg;
                    if (cmp_ok_reg && (crc_stepped == 16'h0000))
                    begin
                        kind_next = KIND_GOOD;
                        len_next  = long_reg ? LEN_LONG : LEN_SHORT;
                    end
                    else
                    begin
                        kind_next = KIND_BAD;
                    end
                end
                default:
                begin
                    // Idle, and any unused code: classify the start byte.
                    phase_next = PH_IDLE;
                    case (in_byte_reg)
                        BYTE_SOH:
                        begin
                            long_next  = 1'b0;
                            phase_next = PH_BLK;
                        end
                        BYTE_STX:
                        begin
                            long_next  = 1'b1;
                            phase_next = PH_BLK;
                        end
                        BYTE_EOT:
                        begin
                            emit      = 1'b1;
                            kind_next = KIND_EOT;
                        end
                        BYTE_CAN:
                        begin
                            phase_next = PH_CAN;
                        end
                        BYTE_UC_C, BYTE_UC_A, BYTE_LC_A:
                        begin
                            emit      = 1'b1;
                            kind_next = KIND_BAD;
                        end
                        default:
                        begin
                            emit      = 1'b1;
                            kind_next = KIND_ABORT;
                        end
                    endcase
                end
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_tmo_reg  <= s_tuser;
        end
    end

    // Deframer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            long_reg   <= 1'b0;
            count_reg  <= 10'd0;
            blk_reg    <= 8'h00;
            cmp_ok_reg <= 1'b0;
            crc_reg    <= 16'h0000;
        end
        else if (consume)
        begin
            phase_reg  <= phase_next;
            long_reg   <= long_next;
            count_reg  <= count_next;
            blk_reg    <= blk_next;
            cmp_ok_reg <= cmp_ok_next;
            crc_reg    <= crc_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume)
        begin
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (consume && emit)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            idx_reg  <= idx_next;
            len_reg  <= len_next;
            oblk_reg <= oblk_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {3'b000, oblk_reg, len_reg, idx_reg, data_reg};

    // A timeout always sends the deframer back to idle.
    a_tmo_idle: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_tmo_reg |=> phase_reg == PH_IDLE)
        else $error("timeout did not return to idle");

    // A short packet never counts past its last payload byte.
    a_short_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA && !long_reg |-> count_reg < 10'd128)
        else $error("short packet byte count overran");

    // An item that yields a result leaves it in the result register.
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        consume && emit |=> out_valid_reg)
        else $error("result lost");

    // The input side stalls only when both registers are occupied and blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without cause");

    // Only a good packet carries a nonzero length.
    a_len_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != KIND_GOOD |-> len_reg == 11'd0)
        else $error("length on a non-good result");

endmodule

`default_nettype wire
